// ===== sv/pxpk_pkg.sv =====
// Package for the pixel channel pack/unpack block: word types, register map and constants.
// Used by pixel_channel_pack_unpack_core; depends on nothing else.
package pxpk_pkg;

    typedef struct packed {
        logic       req_type;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
        logic [7:0] byte0_in;
        logic [7:0] byte1_in;
        logic [7:0] byte2_in;
        logic [7:0] byte3_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] byte0_out;
        logic [7:0] byte1_out;
        logic [7:0] byte2_out;
        logic [7:0] byte3_out;
        logic [2:0] byte_count;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
    } t_pix_out;

    typedef enum logic [2:0] {
        REG_RED_WIDTH     = 3'd0,
        REG_GREEN_WIDTH   = 3'd1,
        REG_BLUE_WIDTH    = 3'd2,
        REG_ALPHA_WIDTH   = 3'd3,
        REG_SWAP_RED_BLUE = 3'd4,
        REG_ALPHA_PRESENT = 3'd5
    } t_reg_idx;

    localparam logic REQ_PACK   = 1'b0;
    localparam logic REQ_UNPACK = 1'b1;

    localparam int         BYTE_BITS = 8;
    localparam logic [7:0] BYTE_ONES = 8'hFF;

    // floor(256 / (2^n - 1)) for a channel of n bits widened to 8; entry 0 unused.
    localparam logic [8:0] UNPACK_GAIN [8] = '{
        9'd0, 9'd256, 9'd85, 9'd36, 9'd17, 9'd8, 9'd4, 9'd2
    };

endpackage

// ===== sv/pixel_channel_pack_unpack_core.sv =====
// Top level of the pixel channel pack/unpack block: APB registers and a two-register pipeline.
// Depends on pxpk_pkg for the word types, register indexes and scaling constants.
//
// Usage:
//   Input channel i_valid/i_data/o_stall carries one word per pixel. req_type 0 packs the
//   four 8-bit channels into 1 to 4 bytes in memory order; req_type 1 unpacks bytes back
//   into four 8-bit channels. The result word appears on o_valid/o_data/i_stall.
//   Channel widths, the red/blue swap and alpha presence are set through the APB port,
//   registers at byte addresses 0, 4, 8, 12, 16 and 20. Change them only while idle.
//   A word accepted into the input register passes the scaling and byte placement logic and
//   is loaded into the result register, which drives o_valid and o_data. Throughput is one
//   word per cycle while i_stall is low, set by the single combinational pass between the
//   two registers, with no dependence between words.
//   While i_stall holds the result register full, the input register still takes one
//   more word; o_stall rises only once both registers are occupied.
//   Reset clears both valid flags and loads the register defaults: 8-bit channels,
//   no swap, alpha present. pready is always high.
module pixel_channel_pack_unpack_core #(
    parameter int MAX_CHANNEL_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  pxpk_pkg::t_pix_in   i_data,
    output logic                o_stall,
    output logic                o_valid,
    output pxpk_pkg::t_pix_out  o_data,
    input  logic                i_stall,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import pxpk_pkg::*;

    localparam int MW  = MAX_CHANNEL_BITS;
    localparam int CW  = $clog2(MAX_CHANNEL_BITS + 1);
    localparam int PW  = $clog2(3 * MAX_CHANNEL_BITS + 1);
    localparam int SW  = $clog2(4 * MAX_CHANNEL_BITS + 1);
    localparam int SZW = SW - 3;

    function automatic logic [MW-1:0] ones(input logic [CW-1:0] n);
        return ~({MW{1'b1}} << n);
    endfunction

    function automatic logic [CW-1:0] clamp_w(input logic [4:0] w);
        if (w > 5'(MAX_CHANNEL_BITS)) begin
            return CW'(MAX_CHANNEL_BITS);
        end
        return w[CW-1:0];
    endfunction

    // 8-bit channel to w bits for packing.
    function automatic logic [MW-1:0] scale_up(input logic [7:0] v, input logic [CW-1:0] w);
        logic [CW-1:0] d;
        logic [MW-1:0] r;
        d = w - CW'(8);
        r = '0;
        if (w < CW'(8)) begin
            r = MW'(v >> (4'd8 - 4'(w)));
        end else if (w == CW'(8)) begin
            r = MW'(v);
        end else if (v == BYTE_ONES) begin
            r = ones(w);
        end else begin
            // floor(2^w / 255) is 2^(w-8), plus one once w reaches 16
            r = (MW'(v) << d) + ((d >= CW'(8)) ? MW'(v) : '0);
        end
        return r;
    endfunction

    // n-bit field to 8 bits for unpacking; the field may carry more bits than n after a swap.
    function automatic logic [7:0] scale_down(input logic [MW-1:0] x, input logic [CW-1:0] n);
        logic [MW-1:0] t;
        logic [16:0]   prod;
        t    = x >> (n - CW'(8));
        prod = 17'(x[7:0]) * 17'(UNPACK_GAIN[n[2:0]]);
        if (n > CW'(8)) begin
            return t[7:0];
        end else if (n == CW'(8)) begin
            return x[7:0];
        end else if (n == '0 || x == ones(n)) begin
            return BYTE_ONES;
        end
        return prod[7:0];
    endfunction

    function automatic logic [31:0] place(input logic [MW-1:0] v, input logic [CW-1:0] mw,
                                          input logic [PW-1:0] pos);
        return 32'(v & ones(mw)) << pos;
    endfunction

    function automatic logic [MW-1:0] pick(input logic [31:0] word, input logic [CW-1:0] mw,
                                           input logic [PW-1:0] pos);
        logic [31:0] t;
        t = word >> pos;
        return t[MW-1:0] & ones(mw);
    endfunction

    // Configuration registers
    logic [4:0] r_red_width;
    logic [4:0] r_green_width;
    logic [4:0] r_blue_width;
    logic [4:0] r_alpha_width;
    logic       r_swap_red_blue;
    logic       r_alpha_present;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_width     <= 5'd8;
            r_green_width   <= 5'd8;
            r_blue_width    <= 5'd8;
            r_alpha_width   <= 5'd8;
            r_swap_red_blue <= 1'b0;
            r_alpha_present <= 1'b1;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_RED_WIDTH:     r_red_width     <= pwdata[4:0];
                REG_GREEN_WIDTH:   r_green_width   <= pwdata[4:0];
                REG_BLUE_WIDTH:    r_blue_width    <= pwdata[4:0];
                REG_ALPHA_WIDTH:   r_alpha_width   <= pwdata[4:0];
                REG_SWAP_RED_BLUE: r_swap_red_blue <= pwdata[0];
                REG_ALPHA_PRESENT: r_alpha_present <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_RED_WIDTH:     prdata = {27'd0, r_red_width};
            REG_GREEN_WIDTH:   prdata = {27'd0, r_green_width};
            REG_BLUE_WIDTH:    prdata = {27'd0, r_blue_width};
            REG_ALPHA_WIDTH:   prdata = {27'd0, r_alpha_width};
            REG_SWAP_RED_BLUE: prdata = {31'd0, r_swap_red_blue};
            REG_ALPHA_PRESENT: prdata = {31'd0, r_alpha_present};
            default:           prdata = '0;
        endcase
    end

    // Derived layout, a function of the registers only
    logic [CW-1:0]  rw, gw, bw, aw;
    logic [PW-1:0]  rs, gs, bs;
    logic [PW-1:0]  red_pos, blue_pos;
    logic [CW-1:0]  red_mw, blue_mw;
    logic [SW-1:0]  total_bits;
    logic [SZW-1:0] size;
    logic           size_ok;

    assign rw = clamp_w(r_red_width);
    assign gw = clamp_w(r_green_width);
    assign bw = clamp_w(r_blue_width);
    assign aw = clamp_w(r_alpha_width);
    assign bs = PW'(aw);
    assign gs = PW'(bw) + PW'(aw);
    assign rs = PW'(gw) + PW'(bw) + PW'(aw);

    // A swap exchanges where red and blue sit and how wide their masks are.
    assign red_pos  = r_swap_red_blue ? bs : rs;
    assign red_mw   = r_swap_red_blue ? bw : rw;
    assign blue_pos = r_swap_red_blue ? rs : bs;
    assign blue_mw  = r_swap_red_blue ? rw : bw;

    assign total_bits = SW'(rw) + SW'(gw) + SW'(bw) + SW'(aw);
    assign size       = total_bits[SW-1:3];
    assign size_ok    = (size != '0) && (size <= SZW'(4));

    // Pipeline control
    logic     r_s1_valid;
    t_pix_in  r_s1_data;
    logic     r_out_valid;
    t_pix_out r_out_data;
    t_pix_out n_out_data;
    logic     out_en;
    logic     s1_en;

    assign out_en  = !r_out_valid || !i_stall;
    assign s1_en   = !r_s1_valid || out_en;
    assign o_stall = !s1_en;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_en) begin
                r_s1_valid <= i_valid;
            end
            if (out_en) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_en && i_valid) begin
            r_s1_data <= i_data;
        end
        if (out_en && r_s1_valid) begin
            r_out_data <= n_out_data;
        end
    end

    // Pack and unpack datapath
    logic [31:0] pack_word;
    logic [31:0] unpack_word;
    logic [7:0]  in_bytes [4];

    assign in_bytes[0] = r_s1_data.byte0_in;
    assign in_bytes[1] = r_s1_data.byte1_in;
    assign in_bytes[2] = r_s1_data.byte2_in;
    assign in_bytes[3] = r_s1_data.byte3_in;

    assign pack_word =
          place(scale_up(r_s1_data.red_in, rw), red_mw, red_pos)
        | place(scale_up(r_s1_data.green_in, gw), gw, gs)
        | place(scale_up(r_s1_data.blue_in, bw), blue_mw, blue_pos)
        | place(scale_up(r_s1_data.alpha_in, aw), aw, '0);

    // Three-byte pixels are stored big-endian, the other sizes little-endian.
    always_comb begin
        unpack_word = '0;
        if (size_ok) begin
            if (size == SZW'(3)) begin
                unpack_word = {8'd0, in_bytes[0], in_bytes[1], in_bytes[2]};
            end else begin
                for (int i = 0; i < 4; i++) begin
                    if (SZW'(i) < size) begin
                        unpack_word[BYTE_BITS*i +: BYTE_BITS] = in_bytes[i];
                    end
                end
            end
        end
    end

    always_comb begin
        logic [7:0] ob [4];
        for (int i = 0; i < 4; i++) begin
            ob[i] = '0;
        end
        n_out_data = '0;
        if (r_s1_data.req_type == REQ_PACK) begin
            if (size_ok) begin
                if (size == SZW'(3)) begin
                    ob[0] = pack_word[23:16];
                    ob[1] = pack_word[15:8];
                    ob[2] = pack_word[7:0];
                end else begin
                    for (int i = 0; i < 4; i++) begin
                        if (SZW'(i) < size) begin
                            ob[i] = pack_word[BYTE_BITS*i +: BYTE_BITS];
                        end
                    end
                end
                n_out_data.byte_count = 3'(size);
            end
            n_out_data.byte0_out = ob[0];
            n_out_data.byte1_out = ob[1];
            n_out_data.byte2_out = ob[2];
            n_out_data.byte3_out = ob[3];
        end else begin
            n_out_data.red_out   = scale_down(pick(unpack_word, red_mw, red_pos), rw);
            n_out_data.green_out = scale_down(pick(unpack_word, gw, gs), gw);
            n_out_data.blue_out  = scale_down(pick(unpack_word, blue_mw, blue_pos), bw);
            n_out_data.alpha_out = r_alpha_present ?
                                   scale_down(pick(unpack_word, aw, '0), aw) : BYTE_ONES;
        end
    end

endmodule
